/* sv/dbd_pkg.sv */
`timescale 1ns / 1ps

package dbd_pkg;

  localparam int SPEED_W = 8;
  localparam int DUTY_W  = 8;
  localparam int MASK_W  = 4;
  localparam int CFG_W   = 8;
  localparam int INDEX_W = 1;

  localparam logic [INDEX_W-1:0] REG_TURN_REDUCTION = 1'd0;
  localparam logic [INDEX_W-1:0] REG_INVERT_MASK    = 1'd1;

  localparam logic [SPEED_W-1:0] TURN_REDUCTION_RESET = 8'd64;
  localparam logic [MASK_W-1:0]  INVERT_MASK_RESET    = 4'd0;

  localparam int WHEEL_FL = 0;
  localparam int WHEEL_FR = 1;
  localparam int WHEEL_RL = 2;
  localparam int WHEEL_RR = 3;

  typedef enum logic [2:0] {
    ACT_STOP      = 3'd0,
    ACT_FWD       = 3'd1,
    ACT_BACK      = 3'd2,
    ACT_LEFT      = 3'd3,
    ACT_RIGHT     = 3'd4,
    ACT_ROT_LEFT  = 3'd5,
    ACT_ROT_RIGHT = 3'd6,
    ACT_STOP_ALT  = 3'd7
  } action_t;

  typedef struct packed {
    logic [SPEED_W-1:0] turn_reduction;
    logic [MASK_W-1:0]  invert_mask;
  } cfg_t;

  typedef struct packed {
    logic [DUTY_W-1:0] fl_fwd_duty;
    logic [DUTY_W-1:0] fl_rev_duty;
    logic [DUTY_W-1:0] fr_fwd_duty;
    logic [DUTY_W-1:0] fr_rev_duty;
    logic [DUTY_W-1:0] rl_fwd_duty;
    logic [DUTY_W-1:0] rl_rev_duty;
    logic [DUTY_W-1:0] rr_fwd_duty;
    logic [DUTY_W-1:0] rr_rev_duty;
    logic              all_stopped;
  } res_t;

endpackage

/* sv/dbd_if.sv */
`timescale 1ns / 1ps

interface dbd_cmd_if;
  import dbd_pkg::*;

  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic [SPEED_W-1:0] speed;

  modport source (output valid, action, speed, input ready);
  modport sink (input valid, action, speed, output ready);
endinterface

interface dbd_duty_if;
  import dbd_pkg::*;

  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] fl_fwd_duty;
  logic [DUTY_W-1:0] fl_rev_duty;
  logic [DUTY_W-1:0] fr_fwd_duty;
  logic [DUTY_W-1:0] fr_rev_duty;
  logic [DUTY_W-1:0] rl_fwd_duty;
  logic [DUTY_W-1:0] rl_rev_duty;
  logic [DUTY_W-1:0] rr_fwd_duty;
  logic [DUTY_W-1:0] rr_rev_duty;
  logic              all_stopped;

  modport source (
    output valid, fl_fwd_duty, fl_rev_duty, fr_fwd_duty, fr_rev_duty,
           rl_fwd_duty, rl_rev_duty, rr_fwd_duty, rr_rev_duty, all_stopped,
    input  ready
  );
  modport sink (
    input  valid, fl_fwd_duty, fl_rev_duty, fr_fwd_duty, fr_rev_duty,
           rl_fwd_duty, rl_rev_duty, rr_fwd_duty, rr_rev_duty, all_stopped,
    output ready
  );
endinterface

/* sv/dbd_cfg.sv */
`timescale 1ns / 1ps

module dbd_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [dbd_pkg::INDEX_W-1:0]  cfg_index,
  input  logic [dbd_pkg::CFG_W-1:0]    cfg_data,
  output dbd_pkg::cfg_t                cfg
);
  import dbd_pkg::*;

  logic [SPEED_W-1:0] turn_reduction;
  logic [MASK_W-1:0]  invert_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      turn_reduction <= TURN_REDUCTION_RESET;
      invert_mask    <= INVERT_MASK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TURN_REDUCTION: turn_reduction <= cfg_data[SPEED_W-1:0];
        REG_INVERT_MASK:    invert_mask    <= cfg_data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.turn_reduction = turn_reduction;
  assign cfg.invert_mask    = invert_mask;

endmodule

/* sv/dbd_mixer.sv */
`timescale 1ns / 1ps

module dbd_mixer (
  input  logic [2:0]                  action,
  input  logic [dbd_pkg::SPEED_W-1:0] speed,
  input  dbd_pkg::cfg_t               cfg,
  output dbd_pkg::res_t               res
);
  import dbd_pkg::*;

  // wheel speed as sign and magnitude; magnitude never exceeds 255, so no clamp
  function automatic logic [2*DUTY_W-1:0] split(input logic neg, input logic inv,
                                                input logic [SPEED_W-1:0] mag);
    logic rev;
    rev = neg ^ inv;
    split = rev ? {{DUTY_W{1'b0}}, mag} : {mag, {DUTY_W{1'b0}}};
  endfunction

  logic [SPEED_W-1:0] inner;
  logic [SPEED_W-1:0] left_mag;
  logic [SPEED_W-1:0] right_mag;
  logic               left_neg;
  logic               right_neg;
  logic               moving;

  assign inner = (speed > cfg.turn_reduction) ? speed - cfg.turn_reduction : '0;

  always_comb begin
    left_mag  = speed;
    right_mag = speed;
    left_neg  = 1'b0;
    right_neg = 1'b0;
    moving    = 1'b1;
    case (action_t'(action))
      ACT_FWD: ;
      ACT_BACK: begin
        left_neg  = 1'b1;
        right_neg = 1'b1;
      end
      ACT_LEFT:      left_mag  = inner;
      ACT_RIGHT:     right_mag = inner;
      ACT_ROT_LEFT:  left_neg  = 1'b1;
      ACT_ROT_RIGHT: right_neg = 1'b1;
      default: begin
        left_mag  = '0;
        right_mag = '0;
        moving    = 1'b0;
      end
    endcase
  end

  assign {res.fl_fwd_duty, res.fl_rev_duty} =
    split(left_neg, cfg.invert_mask[WHEEL_FL], left_mag);
  assign {res.fr_fwd_duty, res.fr_rev_duty} =
    split(right_neg, cfg.invert_mask[WHEEL_FR], right_mag);
  assign {res.rl_fwd_duty, res.rl_rev_duty} =
    split(left_neg, cfg.invert_mask[WHEEL_RL], left_mag);
  assign {res.rr_fwd_duty, res.rr_rev_duty} =
    split(right_neg, cfg.invert_mask[WHEEL_RR], right_mag);
  assign res.all_stopped = ~moving;

endmodule

/* sv/drive_command_to_bridge_duty_top.sv */
`timescale 1ns / 1ps

// Four-wheel skid-steer mixer: each drive command beat (action, speed) becomes
// one beat of eight H-bridge duty values plus the stopped flag. A command
// beat is taken every cycle while cmd.ready is high; its result passes the
// command register and then the result register, with the mixing logic
// between them. Backpressure on the result side stalls both registers in
// turn, so cmd.ready follows duty.ready combinationally when both are full.
// Configuration writes (index 0 turn reduction, 1 invert mask) take effect on
// the next edge and are meant to be made while no beat is in flight.

module drive_command_to_bridge_duty_top (
  input  logic                        clk,
  input  logic                        rst,
  dbd_cmd_if.sink                     cmd,
  dbd_duty_if.source                  duty,
  input  logic                        cfg_we,
  input  logic [dbd_pkg::INDEX_W-1:0] cfg_index,
  input  logic [dbd_pkg::CFG_W-1:0]   cfg_data
);
  import dbd_pkg::*;

  cfg_t               cfg;
  res_t               mix;
  res_t               res;
  logic               res_valid;
  logic               s1_valid;
  logic [2:0]         s1_action;
  logic [SPEED_W-1:0] s1_speed;
  logic               stopped;
  logic               res_load;
  logic               s1_load;

  dbd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dbd_mixer u_mixer (
    .action (s1_action),
    .speed  (s1_speed),
    .cfg    (cfg),
    .res    (mix)
  );

  assign res_load  = ~res_valid | duty.ready;
  assign s1_load   = ~s1_valid | res_load;
  assign cmd.ready = s1_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
      stopped   <= 1'b1;
    end else begin
      if (s1_load) begin
        s1_valid <= cmd.valid;
      end
      if (res_load) begin
        res_valid <= s1_valid;
        if (s1_valid) begin
          stopped <= mix.all_stopped;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && cmd.valid) begin
      s1_action <= cmd.action;
      s1_speed  <= cmd.speed;
    end
    if (res_load && s1_valid) begin
      res <= mix;
    end
  end

  assign duty.valid       = res_valid;
  assign duty.fl_fwd_duty = res.fl_fwd_duty;
  assign duty.fl_rev_duty = res.fl_rev_duty;
  assign duty.fr_fwd_duty = res.fr_fwd_duty;
  assign duty.fr_rev_duty = res.fr_rev_duty;
  assign duty.rl_fwd_duty = res.rl_fwd_duty;
  assign duty.rl_rev_duty = res.rl_rev_duty;
  assign duty.rr_fwd_duty = res.rr_fwd_duty;
  assign duty.rr_rev_duty = res.rr_rev_duty;
  assign duty.all_stopped = stopped;

  assert property (@(posedge clk) rst |=> !duty.valid && !s1_valid)
    else $error("pipeline not empty after reset");

  assert property (@(posedge clk) disable iff (rst)
    duty.valid |-> (res.all_stopped == stopped))
    else $error("stopped flag disagrees with result");

  assert property (@(posedge clk) disable iff (rst)
    (duty.valid && stopped) |->
      (res.fl_fwd_duty == '0 && res.fl_rev_duty == '0 &&
       res.fr_fwd_duty == '0 && res.fr_rev_duty == '0 &&
       res.rl_fwd_duty == '0 && res.rl_rev_duty == '0 &&
       res.rr_fwd_duty == '0 && res.rr_rev_duty == '0))
    else $error("stopped result drives a bridge");

  assert property (@(posedge clk) disable iff (rst)
    duty.valid |->
      ((res.fl_fwd_duty == '0 || res.fl_rev_duty == '0) &&
       (res.fr_fwd_duty == '0 || res.fr_rev_duty == '0) &&
       (res.rl_fwd_duty == '0 || res.rl_rev_duty == '0) &&
       (res.rr_fwd_duty == '0 || res.rr_rev_duty == '0)))
    else $error("bridge driven on both inputs");

  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !res_load) |=> s1_valid && $stable(s1_action) && $stable(s1_speed))
    else $error("stalled command lost");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import dbd_pkg::*;

  class duty_scoreboard;
    res_t              duty_due[$];
    logic [SPEED_W-1:0] turn_red;
    logic [MASK_W-1:0]  inv_mask;
    bit                stopped;
    int                errors;

    function new();
      turn_red = TURN_REDUCTION_RESET;
      inv_mask = INVERT_MASK_RESET;
      stopped  = 1'b1;
      errors   = 0;
    endfunction

    function void set_reg(logic [INDEX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == REG_TURN_REDUCTION) begin
        turn_red = data[SPEED_W-1:0];
      end else if (idx == REG_INVERT_MASK) begin
        inv_mask = data[MASK_W-1:0];
      end
    endfunction

    function void note_command(action_t act, logic [SPEED_W-1:0] spd);
      int                spd_i;
      int                inner;
      int                left;
      int                right;
      int                s;
      int                w;
      int                duty_max;
      bit                moving;
      logic [DUTY_W-1:0] fwd[4];
      logic [DUTY_W-1:0] rev[4];
      res_t              r;
      duty_max = (1 << DUTY_W) - 1;
      spd_i = int'(spd);
      inner = spd_i - int'(turn_red);
      if (inner < 0) inner = 0;
      left = 0;
      right = 0;
      moving = 1'b1;
      case (act)
        ACT_FWD: begin
          left = spd_i;
          right = spd_i;
        end
        ACT_BACK: begin
          left = -spd_i;
          right = -spd_i;
        end
        ACT_LEFT: begin
          left = inner;
          right = spd_i;
        end
        ACT_RIGHT: begin
          left = spd_i;
          right = inner;
        end
        ACT_ROT_LEFT: begin
          left = -spd_i;
          right = spd_i;
        end
        ACT_ROT_RIGHT: begin
          left = spd_i;
          right = -spd_i;
        end
        default: begin
          moving = 1'b0;
        end
      endcase
      for (w = 0; w < 4; w++) begin
        s = (w == WHEEL_FL || w == WHEEL_RL) ? left : right;
        if (inv_mask[w]) s = -s;
        if (s > duty_max) s = duty_max;
        if (s < -duty_max) s = -duty_max;
        fwd[w] = '0;
        rev[w] = '0;
        if (s > 0) begin
          fwd[w] = s[DUTY_W-1:0];
        end else if (s < 0) begin
          s = -s;
          rev[w] = s[DUTY_W-1:0];
        end
      end
      stopped = !moving;
      r.fl_fwd_duty = fwd[WHEEL_FL];
      r.fl_rev_duty = rev[WHEEL_FL];
      r.fr_fwd_duty = fwd[WHEEL_FR];
      r.fr_rev_duty = rev[WHEEL_FR];
      r.rl_fwd_duty = fwd[WHEEL_RL];
      r.rl_rev_duty = rev[WHEEL_RL];
      r.rr_fwd_duty = fwd[WHEEL_RR];
      r.rr_rev_duty = rev[WHEEL_RR];
      r.all_stopped = stopped;
      duty_due.push_back(r);
    endfunction

    function void check_field(string name, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_duty(res_t got);
      res_t want;
      if (duty_due.size() == 0) begin
        $error("duty beat with nothing outstanding");
        errors++;
        return;
      end
      want = duty_due.pop_front();
      check_field("fl_fwd_duty", int'(want.fl_fwd_duty), int'(got.fl_fwd_duty));
      check_field("fl_rev_duty", int'(want.fl_rev_duty), int'(got.fl_rev_duty));
      check_field("fr_fwd_duty", int'(want.fr_fwd_duty), int'(got.fr_fwd_duty));
      check_field("fr_rev_duty", int'(want.fr_rev_duty), int'(got.fr_rev_duty));
      check_field("rl_fwd_duty", int'(want.rl_fwd_duty), int'(got.rl_fwd_duty));
      check_field("rl_rev_duty", int'(want.rl_rev_duty), int'(got.rl_rev_duty));
      check_field("rr_fwd_duty", int'(want.rr_fwd_duty), int'(got.rr_fwd_duty));
      check_field("rr_rev_duty", int'(want.rr_rev_duty), int'(got.rr_rev_duty));
      check_field("all_stopped", int'(want.all_stopped), int'(got.all_stopped));
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [INDEX_W-1:0] cfg_index;
  logic [CFG_W-1:0]   cfg_data;
  bit                 no_gaps;

  duty_scoreboard sb = new();

  dbd_cmd_if  cmd_bus();
  dbd_duty_if duty_bus();

  drive_command_to_bridge_duty_top uut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_bus),
    .duty      (duty_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic send_command(action_t act, logic [SPEED_W-1:0] spd);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_bus.valid  <= 1'b1;
    cmd_bus.action <= act;
    cmd_bus.speed  <= spd;
    @(posedge clk);
    while (!cmd_bus.ready) @(posedge clk);
    sb.note_command(act, spd);
  endtask

  // drop valid and wait for the pipeline to empty
  task automatic settle();
    cmd_bus.valid <= 1'b0;
    while (sb.duty_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [INDEX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  task automatic random_commands(int n);
    int                 i;
    int                 t;
    action_t            act;
    logic [SPEED_W-1:0] spd;
    for (i = 0; i < n; i++) begin
      if (i % 40 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      act = action_t'($urandom_range(0, 7));
      case ($urandom_range(0, 7))
        0: spd = '0;
        1: spd = '1;
        2: begin
          t = int'(sb.turn_red) + int'($urandom_range(0, 2)) - 1;
          if (t < 0) t = 0;
          if (t > 255) t = 255;
          spd = t[SPEED_W-1:0];
        end
        default: spd = SPEED_W'($urandom);
      endcase
      send_command(act, spd);
    end
  endtask

  initial begin : sink_side
    res_t got;
    int   stall;
    duty_bus.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        duty_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      duty_bus.ready <= 1'b1;
      @(posedge clk);
      while (!duty_bus.valid) @(posedge clk);
      got.fl_fwd_duty = duty_bus.fl_fwd_duty;
      got.fl_rev_duty = duty_bus.fl_rev_duty;
      got.fr_fwd_duty = duty_bus.fr_fwd_duty;
      got.fr_rev_duty = duty_bus.fr_rev_duty;
      got.rl_fwd_duty = duty_bus.rl_fwd_duty;
      got.rl_rev_duty = duty_bus.rl_rev_duty;
      got.rr_fwd_duty = duty_bus.rr_fwd_duty;
      got.rr_rev_duty = duty_bus.rr_rev_duty;
      got.all_stopped = duty_bus.all_stopped;
      sb.check_duty(got);
    end
  end

  initial begin : source_side
    int                 p;
    logic [SPEED_W-1:0] tr;
    logic [MASK_W-1:0]  mask;
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_TURN_REDUCTION;
    cfg_data       <= '0;
    cmd_bus.valid  <= 1'b0;
    cmd_bus.action <= ACT_STOP;
    cmd_bus.speed  <= '0;
    no_gaps = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: reduction 64, no inversion
    send_command(ACT_FWD, 8'd0);
    send_command(ACT_STOP, 8'd255);
    send_command(ACT_FWD, 8'd255);
    send_command(ACT_BACK, 8'd255);
    send_command(ACT_LEFT, 8'd255);
    send_command(ACT_RIGHT, 8'd255);
    send_command(ACT_ROT_LEFT, 8'd255);
    send_command(ACT_ROT_RIGHT, 8'd255);
    send_command(ACT_STOP_ALT, 8'd128);
    send_command(ACT_LEFT, 8'd64);
    send_command(ACT_RIGHT, 8'd63);
    send_command(ACT_LEFT, 8'd65);
    send_command(ACT_RIGHT, 8'd1);
    send_command(ACT_BACK, 8'd1);
    send_command(ACT_ROT_LEFT, 8'd0);
    send_command(ACT_STOP_ALT, 8'd0);
    send_command(ACT_FWD, 8'd170);
    send_command(ACT_BACK, 8'd85);
    send_command(ACT_ROT_RIGHT, 8'd0);
    send_command(ACT_STOP, 8'd0);

    for (p = 0; p < 6; p++) begin
      case (p)
        0: begin
          tr = '0;
          mask = '1;
        end
        1: begin
          tr = '1;
          mask = '0;
        end
        2: begin
          tr = '1;
          mask = '1;
        end
        3: begin
          tr = '0;
          mask = '0;
        end
        default: begin
          tr = SPEED_W'($urandom);
          mask = MASK_W'($urandom);
        end
      endcase
      settle();
      write_reg(REG_TURN_REDUCTION, tr);
      write_reg(REG_INVERT_MASK, {4'($urandom), mask});
      random_commands(105);
    end
    settle();

    if (sb.errors == 0 && sb.duty_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
